// ----- hdl/pcfr_pkg.sv -----
// Shared constants, codes and types for the capture FIFO register block.
package pcfr_pkg;

  // Storage sizes
  localparam int SAMPLE_SLOTS = 64;
  localparam int REG_WORDS    = 64;
  localparam int FIFO_AW      = (SAMPLE_SLOTS > 1) ? $clog2(SAMPLE_SLOTS) : 1;
  localparam int FILL_W       = $clog2(SAMPLE_SLOTS + 1);
  localparam int REG_AW       = $clog2(REG_WORDS);
  localparam int WM_W         = 5;
  localparam int CMP_W        = (FILL_W > WM_W) ? FILL_W : WM_W;

  localparam logic [FIFO_AW-1:0] FIFO_LAST = FIFO_AW'(SAMPLE_SLOTS - 1);
  localparam logic [FILL_W-1:0]  FIFO_FULL = FILL_W'(SAMPLE_SLOTS);
  localparam logic [8:0]         REG_LIMIT = 9'(REG_WORDS);

  // Register word indexes
  localparam logic [7:0] IDX_CTRL       = 8'd0;
  localparam logic [7:0] IDX_STAT       = 8'd2;
  localparam logic [7:0] IDX_FIFO_CTRL  = 8'd4;
  localparam logic [7:0] IDX_FIFO_STAT  = 8'd5;
  localparam logic [7:0] IDX_DATA_FIRST = 8'(32'h24 >> 2);
  localparam logic [7:0] IDX_DATA_LAST  = 8'(32'h40 >> 2);
  localparam logic [7:0] IDX_VERSION    = 8'(32'h84 >> 2);
  localparam logic [7:0] IDX_PARAM      = 8'(32'h88 >> 2);

  // Constant register values
  localparam logic [31:0] VERSION_VALUE = 32'h020F_0000;
  localparam logic [31:0] PARAM_VALUE   = 32'h0000_0154;

  // Control register bits
  localparam int CTRL_DISABLE_BIT = 31;
  localparam int CTRL_ENABLE_BIT  = 29;
  localparam int CTRL_SRST_BIT    = 27;
  localparam logic [1:0] SEL_DMA  = 2'b01;

  // Item operation codes
  typedef enum logic [1:0] {
    OP_READ  = 2'd0,
    OP_WRITE = 2'd1,
    OP_TICK  = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  // Where a result's read data comes from
  typedef enum logic [1:0] {
    SRC_IMM  = 2'd0,
    SRC_REG  = 2'd1,
    SRC_FIFO = 2'd2
  } src_t;

  // Sample FIFO command
  typedef struct packed {
    logic        push;
    logic        pop;
    logic        clear;
    logic [31:0] push_data;
  } fifo_cmd_t;

  // Sample FIFO status
  typedef struct packed {
    logic [FILL_W-1:0] fill;
    logic              empty;
    logic              full;
  } fifo_stat_t;

  // Register memory access
  typedef struct packed {
    logic              we;
    logic [REG_AW-1:0] waddr;
    logic [31:0]       wdata;
    logic              re;
    logic [REG_AW-1:0] raddr;
  } reg_acc_t;

  // Sawtooth sample word from the 7-bit phase
  function automatic logic [31:0] saw_word(input logic [6:0] phase);
    logic [15:0] s16;
    s16 = {phase, 9'd0};
    return {s16, s16};
  endfunction

endpackage

// ----- hdl/pcfr_reg_ram.sv -----
// Register storage memory with per-word valid bits and a registered read port.
module pcfr_reg_ram (
  input  logic                 clk,
  input  logic                 rst,
  input  pcfr_pkg::reg_acc_t   acc,
  output logic [31:0]          rd_data
);

  logic [31:0]                mem [pcfr_pkg::REG_WORDS];
  logic [pcfr_pkg::REG_WORDS-1:0] valid;

  // Write storage
  always_ff @(posedge clk) begin
    if (acc.we) begin
      mem[acc.waddr] <= acc.wdata;
    end
  end

  // Mark written words; a word never written reads as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (acc.we) begin
      valid[acc.waddr] <= 1'b1;
    end
  end

  // Registered read, held between reads
  always_ff @(posedge clk) begin
    if (acc.re) begin
      rd_data <= valid[acc.raddr] ? mem[acc.raddr] : 32'd0;
    end
  end

endmodule

// ----- hdl/pcfr_sample_fifo.sv -----
// Receive sample FIFO: memory, pointers and fill count.
module pcfr_sample_fifo (
  input  logic                  clk,
  input  logic                  rst,
  input  pcfr_pkg::fifo_cmd_t   cmd,
  output pcfr_pkg::fifo_stat_t  stat,
  output logic [31:0]           rd_data
);

  logic [31:0]                   mem [pcfr_pkg::SAMPLE_SLOTS];
  logic [pcfr_pkg::FIFO_AW-1:0]  rd_ptr;
  logic [pcfr_pkg::FIFO_AW-1:0]  wr_ptr;
  logic [pcfr_pkg::FILL_W-1:0]   fill;

  assign stat.fill  = fill;
  assign stat.empty = (fill == '0);
  assign stat.full  = (fill == pcfr_pkg::FIFO_FULL);

  // Advance pointers and fill; clear wins
  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      fill   <= '0;
    end else begin
      if (cmd.push) begin
        wr_ptr <= (wr_ptr == pcfr_pkg::FIFO_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (cmd.pop) begin
        rd_ptr <= (rd_ptr == pcfr_pkg::FIFO_LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (cmd.push && !cmd.pop) begin
        fill <= fill + 1'b1;
      end else if (cmd.pop && !cmd.push) begin
        fill <= fill - 1'b1;
      end
    end
  end

  // Store pushed words
  always_ff @(posedge clk) begin
    if (cmd.push) begin
      mem[wr_ptr] <= cmd.push_data;
    end
  end

  // Registered pop read, held until the next pop
  always_ff @(posedge clk) begin
    if (cmd.pop) begin
      rd_data <= mem[rd_ptr];
    end
  end

endmodule

// ----- hdl/pdm_capture_fifo_registers.sv -----
// Top level: item decode, control shadow, result stage and output register.
// The block takes one item (register read, register write or sample tick)
// every cycle unless a stalled result holds it off, and returns exactly
// one result per item, in order. A result passes through the result stage
// and the output register: the accepting edge loads the result stage and
// also performs the synchronous read of the register memory or the sample
// FIFO memory, and the output register is loaded as the result stage drains.
// A stalled result holds the result stage, which holds off the next item.
// Accesses to a memory entry by successive items never meet in the same
// cycle, so no forwarding is needed. The control and watermark registers
// are also held in flip-flops so that every tick sees them at once. No clearing
// pass runs after reset; the block is ready as soon as reset is released.
module pdm_capture_fifo_registers (
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  output logic        item_ready,
  input  logic [1:0]  operation,
  input  logic [7:0]  word_index,
  input  logic [31:0] write_data,
  output logic        result_valid,
  input  logic        result_ready,
  output logic [31:0] read_data,
  output logic        dma_request
);

  // Control shadow and sawtooth phase
  logic [31:0]              ctrl;
  logic [31:0]              ctrl_next;
  logic [pcfr_pkg::WM_W-1:0] watermark;
  logic [pcfr_pkg::WM_W-1:0] watermark_next;
  logic [6:0]               saw;
  logic [6:0]               saw_next;

  // Result stage
  logic                 s1_valid;
  pcfr_pkg::src_t       s1_src;
  logic [31:0]          s1_value;
  logic                 s1_dma;
  pcfr_pkg::src_t       src_next;
  logic [31:0]          value_next;
  logic                 dma_next;

  logic                 accept;
  logic                 s1_adv;
  logic                 running;
  logic                 running_new;
  logic                 in_regs;
  logic                 is_data;
  logic [pcfr_pkg::CMP_W-1:0] fill_after;

  pcfr_pkg::fifo_cmd_t  fifo_cmd;
  pcfr_pkg::fifo_stat_t fifo_stat;
  pcfr_pkg::reg_acc_t   reg_acc;
  logic [31:0]          fifo_rd_data;
  logic [31:0]          reg_rd_data;

  pcfr_sample_fifo u_fifo (
    .clk     (clk),
    .rst     (rst),
    .cmd     (fifo_cmd),
    .stat    (fifo_stat),
    .rd_data (fifo_rd_data)
  );

  pcfr_reg_ram u_regs (
    .clk     (clk),
    .rst     (rst),
    .acc     (reg_acc),
    .rd_data (reg_rd_data)
  );

  // Handshake: take an item unless both the stage and the output are blocked
  assign s1_adv     = s1_valid && (!result_valid || result_ready);
  assign item_ready = !s1_valid || !result_valid || result_ready;
  assign accept     = item_valid && item_ready;

  assign running     = ctrl[pcfr_pkg::CTRL_ENABLE_BIT] && !ctrl[pcfr_pkg::CTRL_DISABLE_BIT];
  assign running_new = write_data[pcfr_pkg::CTRL_ENABLE_BIT]
                       && !write_data[pcfr_pkg::CTRL_DISABLE_BIT];
  assign in_regs     = ({1'b0, word_index} < pcfr_pkg::REG_LIMIT);
  assign is_data     = (word_index >= pcfr_pkg::IDX_DATA_FIRST)
                       && (word_index <= pcfr_pkg::IDX_DATA_LAST);
  assign fill_after  = pcfr_pkg::CMP_W'(fifo_stat.fill)
                       + pcfr_pkg::CMP_W'(fifo_cmd.push);

  // Decode the item: memory commands, shadow updates and the result source
  always_comb begin
    fifo_cmd       = '0;
    reg_acc        = '0;
    reg_acc.waddr  = word_index[pcfr_pkg::REG_AW-1:0];
    reg_acc.raddr  = word_index[pcfr_pkg::REG_AW-1:0];
    reg_acc.wdata  = write_data;
    fifo_cmd.push_data = pcfr_pkg::saw_word(saw);
    ctrl_next      = ctrl;
    watermark_next = watermark;
    saw_next       = saw;
    src_next       = pcfr_pkg::SRC_IMM;
    value_next     = 32'd0;
    dma_next       = 1'b0;
    if (accept) begin
      case (pcfr_pkg::op_t'(operation))
        pcfr_pkg::OP_READ: begin
          if (word_index == pcfr_pkg::IDX_VERSION) begin
            value_next = pcfr_pkg::VERSION_VALUE;
          end else if (word_index == pcfr_pkg::IDX_PARAM) begin
            value_next = pcfr_pkg::PARAM_VALUE;
          end else if (word_index == pcfr_pkg::IDX_STAT
                       || word_index == pcfr_pkg::IDX_FIFO_STAT) begin
            value_next = 32'd0;
          end else if (is_data) begin
            if (!fifo_stat.empty) begin
              fifo_cmd.pop = 1'b1;
              src_next     = pcfr_pkg::SRC_FIFO;
            end else if (running) begin
              value_next = pcfr_pkg::saw_word(saw);
              saw_next   = saw + 7'd1;
            end
          end else if (word_index == pcfr_pkg::IDX_CTRL) begin
            value_next = ctrl;
          end else if (in_regs) begin
            reg_acc.re = 1'b1;
            src_next   = pcfr_pkg::SRC_REG;
          end
        end
        pcfr_pkg::OP_WRITE: begin
          if (word_index == pcfr_pkg::IDX_CTRL) begin
            // Soft reset is self-clearing; start and stop also flush
            ctrl_next = write_data;
            ctrl_next[pcfr_pkg::CTRL_SRST_BIT] = 1'b0;
            fifo_cmd.clear = write_data[pcfr_pkg::CTRL_SRST_BIT]
                             || (running_new != running);
          end else if (word_index != pcfr_pkg::IDX_VERSION
                       && word_index != pcfr_pkg::IDX_PARAM && in_regs) begin
            reg_acc.we = 1'b1;
            if (word_index == pcfr_pkg::IDX_FIFO_CTRL) begin
              watermark_next = write_data[pcfr_pkg::WM_W-1:0];
            end
          end
        end
        pcfr_pkg::OP_TICK: begin
          if (running) begin
            if (!fifo_stat.full) begin
              fifo_cmd.push = 1'b1;
              saw_next      = saw + 7'd1;
            end
            dma_next = (ctrl[25:24] == pcfr_pkg::SEL_DMA)
                       && (fill_after > pcfr_pkg::CMP_W'(watermark));
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Hold control state
  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl      <= '0;
      watermark <= '0;
      saw       <= '0;
    end else begin
      ctrl      <= ctrl_next;
      watermark <= watermark_next;
      saw       <= saw_next;
    end
  end

  // Result stage: load on accept, drain into the output register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_src   <= src_next;
      s1_value <= value_next;
      s1_dma   <= dma_next;
    end
  end

  // Output register: select memory data once it has been read
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (s1_adv) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      dma_request <= s1_dma;
      case (s1_src)
        pcfr_pkg::SRC_REG:  read_data <= reg_rd_data;
        pcfr_pkg::SRC_FIFO: read_data <= fifo_rd_data;
        default:            read_data <= s1_value;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fifo_stat.fill <= pcfr_pkg::FIFO_FULL)
    else $error("sample FIFO fill beyond depth");

  a_stopped_tick: assert property (@(posedge clk) disable iff (rst)
    (accept && operation == pcfr_pkg::OP_TICK && !running)
      |=> (fifo_stat.fill == $past(fifo_stat.fill)) && $stable(saw))
    else $error("tick while stopped changed FIFO state");

  a_item_staged: assert property (@(posedge clk) disable iff (rst)
    accept |=> s1_valid)
    else $error("accepted item lost before result stage");

  a_no_push_pop: assert property (@(posedge clk) disable iff (rst)
    !(fifo_cmd.push && (fifo_cmd.pop || fifo_cmd.clear)))
    else $error("push collides with pop or clear");
`endif

endmodule
